>>> src/acsd_pkg.sv
// Shared types, codes and constants for the audio chunk stream decoder.
package acsd_pkg;

	// Input item: one byte of the chunk
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_chunk;
	} in_t;

	// Result item
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] sample_word;
		logic [30:0] channel_number;
		logic [30:0] sample_number;
		logic [1:0]  detected_format;
		logic [63:0] rate_bits;
		logic [30:0] channel_total;
		logic [30:0] samples_per_channel;
		logic [2:0]  error_code;
		logic        chunk_done;
	} out_t;

	// Parser phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_SAMPLES = 3'b010,
		PH_DRAIN   = 3'b100
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_UNRECOGNISED = 3'd1;
	localparam logic [2:0] ERR_BAD_MAGIC    = 3'd2;
	localparam logic [2:0] ERR_BAD_VERSION  = 3'd3;
	localparam logic [2:0] ERR_BAD_DIMS     = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED    = 3'd5;

	// Sample codings as reported
	localparam logic [1:0] FMT_FLOAT32 = 2'd0;
	localparam logic [1:0] FMT_PCM24   = 2'd1;
	localparam logic [1:0] FMT_PCM16   = 2'd2;
	localparam logic [1:0] FMT_NONE    = 2'd3;

	// Expected-format register codes
	localparam logic [1:0] EXP_DETECT = 2'd0;

	// Magic words
	localparam logic [31:0] MAGIC_F32 = 32'h4841_4632;
	localparam logic [31:0] MAGIC_P16 = 32'h4841_5031;
	localparam logic [31:0] MAGIC_P24 = 32'h4841_5032;
	localparam logic [31:0] VERSION_ONE = 32'd1;

	// Header byte positions
	localparam logic [4:0] HDR_MAGIC_LAST   = 5'd3;
	localparam logic [4:0] HDR_VERSION_LAST = 5'd7;
	localparam logic [4:0] HDR_RATE_FIRST   = 5'd8;
	localparam logic [4:0] HDR_RATE_LAST    = 5'd15;
	localparam logic [4:0] HDR_CHANS_LAST   = 5'd19;
	localparam logic [4:0] HDR_SAMPS_LAST   = 5'd23;

	// Bytes per sample, modulo four
	localparam logic [1:0] NEED_F32 = 2'd0;
	localparam logic [1:0] NEED_P24 = 2'd3;
	localparam logic [1:0] NEED_P16 = 2'd2;

	// Result queue depth
	localparam int QUEUE_DEPTH_DEF = 4;

endpackage

>>> src/acsd_front.sv
// Front end: byte-wise chunk parser that classifies each byte and builds results.
module acsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  acsd_pkg::in_t       byte_item,
	input  logic [1:0]          expected_format,
	output logic                res_valid,
	output acsd_pkg::out_t      res_item
);

	acsd_pkg::phase_t phase_q, phase_d;
	logic [4:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] word_q, word_d;
	logic [1:0]  fmt_q, fmt_d;
	logic [63:0] rate_q, rate_d;
	logic [30:0] chans_q, chans_d;
	logic [30:0] samps_q, samps_d;
	logic [30:0] ch_q, ch_d;
	logic [30:0] sn_q, sn_d;
	logic [1:0]  bis_q, bis_d;

	logic [7:0]  b;
	logic        eoc;
	logic [31:0] ws;
	logic [1:0]  magic_fmt;
	logic [1:0]  need;
	logic [1:0]  bis_inc;
	logic [30:0] sn_inc;
	logic [30:0] ch_inc;
	logic        last;
	logic [31:0] smp_word;
	logic        err_hit;
	logic [2:0]  err_code;
	logic        finish;
	logic        good_hit;
	logic [1:0]  good_kind;
	logic        good_done;

	assign b   = byte_item.data_byte;
	assign eoc = byte_item.end_of_chunk;
	assign ws  = {b, word_q[31:8]};

	// Magic word lookup
	always_comb begin
		if (ws == acsd_pkg::MAGIC_F32) begin
			magic_fmt = acsd_pkg::FMT_FLOAT32;
		end else if (ws == acsd_pkg::MAGIC_P24) begin
			magic_fmt = acsd_pkg::FMT_PCM24;
		end else if (ws == acsd_pkg::MAGIC_P16) begin
			magic_fmt = acsd_pkg::FMT_PCM16;
		end else begin
			magic_fmt = acsd_pkg::FMT_NONE;
		end
	end

	// Bytes needed per sample and the sample counters' next values
	always_comb begin
		unique case (fmt_q)
			acsd_pkg::FMT_FLOAT32: need = acsd_pkg::NEED_F32;
			acsd_pkg::FMT_PCM24:   need = acsd_pkg::NEED_P24;
			default:               need = acsd_pkg::NEED_P16;
		endcase
	end

	assign bis_inc = bis_q + 2'd1;
	assign sn_inc  = sn_q + 31'd1;
	assign ch_inc  = ch_q + 31'd1;

	// Sample word: PCM left-aligned into Q1.31, float passed as raw bits
	always_comb begin
		plain_mask : begin
			smp_word = ws;
			if (need == acsd_pkg::NEED_P24) begin
				smp_word = {ws[31:8], 8'h00};
			end else if (need == acsd_pkg::NEED_P16) begin
				smp_word = {ws[31:16], 16'h0000};
			end
		end
	end

	// Per-byte step
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		word_d    = word_q;
		fmt_d     = fmt_q;
		rate_d    = rate_q;
		chans_d   = chans_q;
		samps_d   = samps_q;
		ch_d      = ch_q;
		sn_d      = sn_q;
		bis_d     = bis_q;
		err_hit   = 1'b0;
		err_code  = acsd_pkg::ERR_NONE;
		finish    = 1'b0;
		good_hit  = 1'b0;
		good_kind = acsd_pkg::KIND_HEADER;
		good_done = 1'b0;
		last      = 1'b0;

		unique case (phase_q)
			acsd_pkg::PH_HEADER: begin
				word_d    = ws;
				hdr_cnt_d = hdr_cnt_q + 5'd1;
				if (hdr_cnt_q >= acsd_pkg::HDR_RATE_FIRST &&
				    hdr_cnt_q <= acsd_pkg::HDR_RATE_LAST) begin
					rate_d = {b, rate_q[63:8]};
				end
				if (hdr_cnt_q == acsd_pkg::HDR_MAGIC_LAST) begin
					if (expected_format == acsd_pkg::EXP_DETECT &&
					    magic_fmt == acsd_pkg::FMT_NONE) begin
						err_hit  = 1'b1;
						err_code = acsd_pkg::ERR_UNRECOGNISED;
					end else if (expected_format != acsd_pkg::EXP_DETECT &&
					             magic_fmt != expected_format - 2'd1) begin
						err_hit  = 1'b1;
						err_code = acsd_pkg::ERR_BAD_MAGIC;
					end else begin
						fmt_d = magic_fmt;
						if (eoc) begin
							err_hit  = 1'b1;
							err_code = acsd_pkg::ERR_TRUNCATED;
						end
					end
				end else if (hdr_cnt_q == acsd_pkg::HDR_VERSION_LAST) begin
					err_hit  = 1'b1;
					if (ws != acsd_pkg::VERSION_ONE) begin
						err_code = acsd_pkg::ERR_BAD_VERSION;
					end else begin
						err_hit  = eoc;
						err_code = acsd_pkg::ERR_TRUNCATED;
					end
				end else if (hdr_cnt_q == acsd_pkg::HDR_CHANS_LAST) begin
					if (ws == 32'd0 || ws[31]) begin
						err_hit  = 1'b1;
						err_code = acsd_pkg::ERR_BAD_DIMS;
					end else begin
						chans_d = ws[30:0];
						if (eoc) begin
							err_hit  = 1'b1;
							err_code = acsd_pkg::ERR_TRUNCATED;
						end
					end
				end else if (hdr_cnt_q >= acsd_pkg::HDR_SAMPS_LAST) begin
					if (ws[31]) begin
						err_hit  = 1'b1;
						err_code = acsd_pkg::ERR_BAD_DIMS;
					end else begin
						samps_d = ws[30:0];
						ch_d    = '0;
						sn_d    = '0;
						bis_d   = '0;
						if (ws[30:0] == 31'd0) begin
							// empty chunk: header closes it
							good_hit  = 1'b1;
							good_done = 1'b1;
							finish    = 1'b1;
						end else if (eoc) begin
							err_hit  = 1'b1;
							err_code = acsd_pkg::ERR_TRUNCATED;
						end else begin
							good_hit  = 1'b1;
							hdr_cnt_d = '0;
							phase_d   = acsd_pkg::PH_SAMPLES;
						end
					end
				end else if (eoc) begin
					err_hit = 1'b1;
					if (hdr_cnt_q < acsd_pkg::HDR_MAGIC_LAST) begin
						err_code = (expected_format == acsd_pkg::EXP_DETECT) ?
						           acsd_pkg::ERR_UNRECOGNISED : acsd_pkg::ERR_BAD_MAGIC;
					end else begin
						err_code = acsd_pkg::ERR_TRUNCATED;
					end
				end
			end

			acsd_pkg::PH_SAMPLES: begin
				word_d = ws;
				bis_d  = bis_inc;
				if (bis_inc == need) begin
					bis_d = '0;
					sn_d  = sn_inc;
					if (sn_inc >= samps_q) begin
						sn_d = '0;
						ch_d = ch_inc;
						last = (ch_inc >= chans_q);
					end
					if (!last && eoc) begin
						err_hit  = 1'b1;
						err_code = acsd_pkg::ERR_TRUNCATED;
					end else begin
						good_hit  = 1'b1;
						good_kind = acsd_pkg::KIND_SAMPLE;
						good_done = last;
						finish    = last;
					end
				end else if (eoc) begin
					err_hit  = 1'b1;
					err_code = acsd_pkg::ERR_TRUNCATED;
				end
			end

			default: begin
				// drain: skip bytes until the chunk ends
				finish = eoc;
			end
		endcase

		if (err_hit) begin
			finish = 1'b1;
		end
		if (finish) begin
			phase_d   = eoc ? acsd_pkg::PH_HEADER : acsd_pkg::PH_DRAIN;
			hdr_cnt_d = '0;
			bis_d     = '0;
		end
	end

	// Result assembly
	always_comb begin
		res_item  = '0;
		res_valid = accept && (err_hit || good_hit);
		if (err_hit) begin
			res_item.result_kind = acsd_pkg::KIND_ERROR;
			res_item.error_code  = err_code;
			res_item.chunk_done  = 1'b1;
		end else begin
			res_item.result_kind         = good_kind;
			res_item.detected_format     = fmt_d;
			res_item.rate_bits           = rate_d;
			res_item.channel_total       = chans_d;
			res_item.samples_per_channel = samps_d;
			res_item.chunk_done          = good_done;
			if (good_kind == acsd_pkg::KIND_SAMPLE) begin
				res_item.sample_word    = smp_word;
				res_item.channel_number = ch_q;
				res_item.sample_number  = sn_q;
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= acsd_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			word_q    <= '0;
			fmt_q     <= '0;
			rate_q    <= '0;
			chans_q   <= '0;
			samps_q   <= '0;
			ch_q      <= '0;
			sn_q      <= '0;
			bis_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			word_q    <= word_d;
			fmt_q     <= fmt_d;
			rate_q    <= rate_d;
			chans_q   <= chans_d;
			samps_q   <= samps_d;
			ch_q      <= ch_d;
			sn_q      <= sn_d;
			bis_q     <= bis_d;
		end
	end

`ifndef SYNTH
	// every error closes the chunk
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.result_kind == acsd_pkg::KIND_ERROR |-> res_item.chunk_done)
		else $error("error result without chunk_done");

	// before the magic word is complete only errors come out
	a_early_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && phase_q == acsd_pkg::PH_HEADER &&
		hdr_cnt_q < acsd_pkg::HDR_MAGIC_LAST |->
		res_item.result_kind == acsd_pkg::KIND_ERROR)
		else $error("non-error result inside magic word");

	// drain holds until the chunk's last byte
	a_drain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == acsd_pkg::PH_DRAIN && !(accept && byte_item.end_of_chunk) |=>
		phase_q == acsd_pkg::PH_DRAIN)
		else $error("drain left early");
`endif

endmodule

>>> src/acsd_queue.sv
// Back end: result queue that decouples the parser from the result consumer.
module acsd_queue #(
	parameter int DEPTH = acsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  acsd_pkg::out_t wr_item,
	input  logic           rd,
	output acsd_pkg::out_t rd_item,
	output logic           full,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	acsd_pkg::out_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	// Slot storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue level above depth");

	a_level_up: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == CW'($past(cnt_q) + 1'b1))
		else $error("queue level did not rise on write");

	a_level_down: assert property (@(posedge clk) disable iff (!arst_n)
		rd && !wr |=> cnt_q == CW'($past(cnt_q) - 1'b1))
		else $error("queue level did not fall on read");
`endif

endmodule

>>> src/audio_chunk_stream_decoder_top.sv
// A result item enters the result queue at the accepting edge and shows on the result ports once at its head.
// Throughput: one byte per cycle while full is low; each byte yields at most one result item.
// full rises only when QUEUE_DEPTH results wait unpopped in the result queue.
// Reset (arst_n low, asynchronous) returns the parser to the header phase,
// empties the queue and sets expected_format to detect-by-magic.
module audio_chunk_stream_decoder_top #(
	parameter int QUEUE_DEPTH = acsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  acsd_pkg::in_t  byte_item,
	output logic           empty,
	input  logic           pop,
	output acsd_pkg::out_t result,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_data
);

	logic [1:0]     exp_fmt_q;
	logic           accept;
	logic           res_valid;
	acsd_pkg::out_t res_item;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_fmt_q <= acsd_pkg::EXP_DETECT;
		end else if (cfg_we) begin
			exp_fmt_q <= cfg_data;
		end
	end

	assign accept = push && !full;

	acsd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.byte_item       (byte_item),
		.expected_format (exp_fmt_q),
		.res_valid       (res_valid),
		.res_item        (res_item)
	);

	acsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_valid),
		.wr_item (res_item),
		.rd      (pop && !empty),
		.rd_item (result),
		.full    (full),
		.empty   (empty)
	);

endmodule
